// ----- design/nau_pkg.sv -----
package nau_pkg;

	// Default geometry of the element format and of the interpolation tables.
	localparam int DATA_WIDTH_DEF  = 16;
	localparam int FRAC_BITS_DEF   = 12;
	localparam int TABLE_DEPTH_DEF = 256;

	// Number of register stages between the input and the output transaction.
	localparam int NUM_STAGES = 6;

	// Function selector codes.
	localparam int FN_W = 3;
	localparam logic [FN_W-1:0] FN_SIGMOID   = 3'd0;
	localparam logic [FN_W-1:0] FN_SIGMOID_D = 3'd1;
	localparam logic [FN_W-1:0] FN_RELU      = 3'd2;
	localparam logic [FN_W-1:0] FN_RELU_D    = 3'd3;
	localparam logic [FN_W-1:0] FN_LEAKY     = 3'd4;
	localparam logic [FN_W-1:0] FN_LEAKY_D   = 3'd5;
	localparam logic [FN_W-1:0] FN_TANH      = 3'd6;
	localparam logic [FN_W-1:0] FN_TANH_D    = 3'd7;

	// Leaky slope of 41/4096 with round-half-up.
	localparam int LEAK_NUM   = 41;
	localparam int LEAK_SHIFT = 12;
	localparam int LEAK_RND   = 1 << (LEAK_SHIFT - 1);

	// Fixed-point format used while the tables are built.
	localparam int          Q30     = 30;
	localparam logic [63:0] Q30_ONE = 64'd1 << Q30;
	localparam logic [63:0] T_CAP   = 64'd70 << Q30;

	typedef struct packed {
		logic [FN_W-1:0] sel;
		logic            neg;
	} nau_tag_t;

	// Signed width that holds every unsaturated result.
	function automatic int res_width(input int dw, input int fb);
		int w;
		w = (dw > fb + 1) ? dw : fb + 1;
		return w + 1;
	endfunction

	// Shift-and-subtract division, only evaluated while the tables are built.
	function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		logic [63:0] rem;
		q   = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem  = rem - den;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] exp_pos_series(input logic [63:0] u);
		logic [63:0] sum;
		logic [63:0] term;
		logic        done;
		sum  = Q30_ONE;
		term = Q30_ONE;
		done = 1'b0;
		for (int n = 1; n <= 40; n++) begin
			if (!done) begin
				term = div_u64((term * u) >> Q30, 64'(n));
				if (term == '0) begin
					done = 1'b1;
				end else begin
					sum = sum + term;
				end
			end
		end
		return sum;
	endfunction

	function automatic logic [63:0] recip_q30(input logic [63:0] v);
		return div_u64((64'd1 << 60) + (v >> 1), v);
	endfunction

	function automatic logic [63:0] exp_neg(input logic [63:0] t, input logic [63:0] einv);
		logic [63:0] whole;
		logic [63:0] r;
		whole = t >> Q30;
		if (whole >= 64'd64) begin
			return '0;
		end
		r = recip_q30(exp_pos_series(t & (Q30_ONE - 64'd1)));
		for (int n = 0; n < 64; n++) begin
			if (64'(n) < whole) begin
				r = (r * einv + (Q30_ONE >> 1)) >> Q30;
			end
		end
		return r;
	endfunction

	// Table point k of the sigmoid (tanh_sel low) or tanh (tanh_sel high) table.
	function automatic logic [63:0] table_point(input int k, input int dw, input int fb,
			input int depth, input logic tanh_sel);
		logic [63:0] einv;
		logic [63:0] lsb;
		logic [63:0] t;
		logic [63:0] e1;
		logic [63:0] e2;
		logic [63:0] d1;
		logic [63:0] d2;
		einv = recip_q30(exp_pos_series(Q30_ONE));
		lsb  = div_u64(64'(k) << (dw - 1), 64'(depth));
		t    = (lsb > (T_CAP >> (Q30 - fb))) ? T_CAP : (lsb << (Q30 - fb));
		e1   = exp_neg(t, einv);
		e2   = exp_neg(t << 1, einv);
		d1   = Q30_ONE + e1;
		d2   = Q30_ONE + e2;
		if (tanh_sel) begin
			return div_u64(((Q30_ONE - e2) << fb) + (d2 >> 1), d2);
		end
		return div_u64((64'd1 << (fb + Q30)) + (d1 >> 1), d1);
	endfunction

endpackage

// ----- design/nau_x_if.sv -----
interface nau_x_if
	import nau_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) ();
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] x_value;

	modport source (output valid, output x_value, input ready);
	modport sink (input valid, input x_value, output ready);
endinterface

// ----- design/nau_y_if.sv -----
interface nau_y_if
	import nau_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) ();
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] y_value;

	modport source (output valid, output y_value, input ready);
	modport sink (input valid, input y_value, output ready);
endinterface

// ----- design/neural_activation_unit.sv -----
// Channel         Role     Handshake      Payload
// x_stream        input    valid/ready    x_value, signed Q4.12 element
// y_stream        output   valid/ready    y_value, signed Q4.12 result
// cfg_write_en    config   write strobe   cfg_write_data, function selector
//
// One transaction is accepted per clock while the output is not stalled; each
// result passes through the six register stages of the datapath to the output.
// Reset (arst_n low) clears the stage valid bits and selects the sigmoid.
// Each stage holds its item while the next stage is occupied and stalled, so a
// bubble anywhere in the pipeline still lets a new input transaction in while a
// finished result waits at the output register.
module neural_activation_unit
	import nau_pkg::*;
#(
	parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_write_en,
	input  logic [FN_W-1:0] cfg_write_data,
	nau_x_if.sink           x_stream,
	nau_y_if.source         y_stream
);
	localparam int RW = res_width(DATA_WIDTH, FRAC_BITS);

	// The user must write the selector only while the pipeline is empty; the block itself does not enforce this.
	logic [FN_W-1:0] function_select_q;

	// One valid bit per stage; stage k may load when it is empty or when the
	// stage after it is moving on in the same cycle.
	logic [NUM_STAGES-1:0] stage_valid_q;
	logic [NUM_STAGES-1:0] stage_ready;
	logic [NUM_STAGES-1:0] valid_in;

	nau_tag_t                     tag_s3;
	logic [FRAC_BITS:0]           lo_s3;
	logic [FRAC_BITS:0]           d_s3;
	logic [DATA_WIDTH-2:0]        r_s3;
	logic signed [RW-1:0]         lin_s3;
	logic signed [DATA_WIDTH-1:0] y_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			function_select_q <= FN_SIGMOID;
		end else if (cfg_write_en) begin
			function_select_q <= cfg_write_data;
		end
	end

	always_comb begin
		stage_ready[NUM_STAGES-1] = !stage_valid_q[NUM_STAGES-1] || y_stream.ready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			stage_ready[k] = !stage_valid_q[k] || stage_ready[k+1];
		end
	end

	assign valid_in = {stage_valid_q[NUM_STAGES-2:0], x_stream.valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q <= '0;
		end else begin
			for (int k = 0; k < NUM_STAGES; k++) begin
				if (stage_ready[k]) begin
					stage_valid_q[k] <= valid_in[k];
				end
			end
		end
	end

	assign x_stream.ready   = stage_ready[0];
	assign y_stream.valid   = stage_valid_q[NUM_STAGES-1];
	assign y_stream.y_value = y_s6;

	// Stages one to three: magnitude, table position, table read.
	nau_interp #(
		.DATA_WIDTH  (DATA_WIDTH),
		.FRAC_BITS   (FRAC_BITS),
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_interp (
		.clk             (clk),
		.en              (stage_ready[2:0]),
		.x_value         (x_stream.x_value),
		.function_select (function_select_q),
		.tag_s3          (tag_s3),
		.lo_s3           (lo_s3),
		.d_s3            (d_s3),
		.r_s3            (r_s3),
		.lin_s3          (lin_s3)
	);

	// Stages four to six: interpolation, derivative product, saturation.
	nau_shape #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_shape (
		.clk    (clk),
		.en     (stage_ready[5:3]),
		.tag_s3 (tag_s3),
		.lo_s3  (lo_s3),
		.d_s3   (d_s3),
		.r_s3   (r_s3),
		.lin_s3 (lin_s3),
		.y_s6   (y_s6)
	);

`ifndef NO_ASSERTIONS
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(x_stream.valid && x_stream.ready) |=> stage_valid_q[0])
		else $error("accepted transaction did not reach the first stage");

	a_ready_passes: assert property (@(posedge clk) disable iff (!arst_n)
		y_stream.ready |-> x_stream.ready)
		else $error("input stalled although the output is taken");

	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		((&stage_valid_q) && !y_stream.ready) |-> !x_stream.ready)
		else $error("input accepted while every stage is occupied and stalled");

	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write_en |=> (function_select_q == $past(cfg_write_data)))
		else $error("function selector write lost");
`endif

endmodule

// ----- design/nau_table.sv -----
module nau_table
	import nau_pkg::*;
#(
	parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic [$clog2(TABLE_DEPTH+1)-1:0] idx,
	output logic [FRAC_BITS:0]               sig_lo,
	output logic [FRAC_BITS:0]               sig_d,
	output logic [FRAC_BITS:0]               tanh_lo,
	output logic [FRAC_BITS:0]               tanh_d
);
	localparam int TW = FRAC_BITS + 1;
	localparam int XW = $clog2(TABLE_DEPTH + 1);
	localparam int IW = $clog2(TABLE_DEPTH);

	// Each row holds a point and the rising step to the next point.
	localparam logic [63:0] S_END = table_point(TABLE_DEPTH, DATA_WIDTH, FRAC_BITS,
		TABLE_DEPTH, 1'b0);
	localparam logic [63:0] H_END = table_point(TABLE_DEPTH, DATA_WIDTH, FRAC_BITS,
		TABLE_DEPTH, 1'b1);

	logic [TW-1:0] sig_lo_rom  [TABLE_DEPTH];
	logic [TW-1:0] sig_d_rom   [TABLE_DEPTH];
	logic [TW-1:0] tanh_lo_rom [TABLE_DEPTH];
	logic [TW-1:0] tanh_d_rom  [TABLE_DEPTH];

	for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_row
		localparam logic [63:0] S0 = table_point(k, DATA_WIDTH, FRAC_BITS, TABLE_DEPTH, 1'b0);
		localparam logic [63:0] S1 = table_point(k + 1, DATA_WIDTH, FRAC_BITS, TABLE_DEPTH,
			1'b0);
		localparam logic [63:0] H0 = table_point(k, DATA_WIDTH, FRAC_BITS, TABLE_DEPTH, 1'b1);
		localparam logic [63:0] H1 = table_point(k + 1, DATA_WIDTH, FRAC_BITS, TABLE_DEPTH,
			1'b1);
		localparam logic [63:0] SD = (S1 >= S0) ? (S1 - S0) : 64'd0;
		localparam logic [63:0] HD = (H1 >= H0) ? (H1 - H0) : 64'd0;

		assign sig_lo_rom[k]  = S0[TW-1:0];
		assign sig_d_rom[k]   = SD[TW-1:0];
		assign tanh_lo_rom[k] = H0[TW-1:0];
		assign tanh_d_rom[k]  = HD[TW-1:0];
	end

	// The last point is only reached by the most negative input, with no remainder.
	always_comb begin
		if (idx == XW'(TABLE_DEPTH)) begin
			sig_lo  = S_END[TW-1:0];
			sig_d   = '0;
			tanh_lo = H_END[TW-1:0];
			tanh_d  = '0;
		end else begin
			sig_lo  = sig_lo_rom[idx[IW-1:0]];
			sig_d   = sig_d_rom[idx[IW-1:0]];
			tanh_lo = tanh_lo_rom[idx[IW-1:0]];
			tanh_d  = tanh_d_rom[idx[IW-1:0]];
		end
	end

endmodule

// ----- design/nau_interp.sv -----
module nau_interp
	import nau_pkg::*;
#(
	parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                                                 clk,
	input  logic [2:0]                                           en,
	input  logic signed [DATA_WIDTH-1:0]                         x_value,
	input  logic [FN_W-1:0]                                      function_select,
	output nau_tag_t                                             tag_s3,
	output logic [FRAC_BITS:0]                                   lo_s3,
	output logic [FRAC_BITS:0]                                   d_s3,
	output logic [DATA_WIDTH-2:0]                                r_s3,
	output logic signed [res_width(DATA_WIDTH, FRAC_BITS)-1:0] lin_s3
);
	localparam int TW = FRAC_BITS + 1;
	localparam int XW = $clog2(TABLE_DEPTH + 1);
	localparam int PW = DATA_WIDTH + XW;
	localparam int LW = DATA_WIDTH + 7;
	localparam int RW = res_width(DATA_WIDTH, FRAC_BITS);

	localparam logic signed [RW-1:0] ONE_R    = RW'(longint'(1) << FRAC_BITS);
	localparam logic signed [RW-1:0] LEAK_D_R =
		RW'(((longint'(LEAK_NUM) << FRAC_BITS) + LEAK_RND) >> LEAK_SHIFT);

	logic signed [DATA_WIDTH-1:0] x_s1;
	nau_tag_t                     tag_s1;
	nau_tag_t                     tag_s2;
	logic [XW-1:0]                idx_s2;
	logic [DATA_WIDTH-2:0]        r_s2;
	logic signed [RW-1:0]         lin_s2;

	logic [DATA_WIDTH-1:0] mag;
	logic [PW-1:0]         pos_scaled;
	logic [LW-1:0]         leak;
	logic                  pos;
	logic signed [RW-1:0]  x_ext;
	logic signed [RW-1:0]  lin;
	logic [TW-1:0]         sig_lo;
	logic [TW-1:0]         sig_d;
	logic [TW-1:0]         tanh_lo;
	logic [TW-1:0]         tanh_d;
	logic                  use_tanh;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			x_s1       <= x_value;
			tag_s1.sel <= function_select;
			tag_s1.neg <= x_value[DATA_WIDTH-1];
		end
	end

	// Magnitude, table position and the piecewise-linear functions.
	assign mag        = x_s1[DATA_WIDTH-1] ? ($unsigned(~x_s1) + 1'b1) : $unsigned(x_s1);
	assign pos_scaled = PW'(mag) * PW'(TABLE_DEPTH);
	assign leak       = (LW'(mag) * LW'(LEAK_NUM) + LW'(LEAK_RND)) >> LEAK_SHIFT;
	assign pos        = !x_s1[DATA_WIDTH-1] && (x_s1 != '0);
	assign x_ext      = {{(RW-DATA_WIDTH){x_s1[DATA_WIDTH-1]}}, x_s1};

	always_comb begin
		case (tag_s1.sel)
			FN_RELU:    lin = pos ? x_ext : '0;
			FN_RELU_D:  lin = pos ? ONE_R : '0;
			FN_LEAKY:   lin = pos ? x_ext : (RW'(0) - RW'(leak));
			FN_LEAKY_D: lin = pos ? ONE_R : LEAK_D_R;
			default:    lin = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			tag_s2 <= tag_s1;
			idx_s2 <= XW'(pos_scaled >> (DATA_WIDTH - 1));
			r_s2   <= pos_scaled[DATA_WIDTH-2:0];
			lin_s2 <= lin;
		end
	end

	nau_table #(
		.DATA_WIDTH  (DATA_WIDTH),
		.FRAC_BITS   (FRAC_BITS),
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_table (
		.idx     (idx_s2),
		.sig_lo  (sig_lo),
		.sig_d   (sig_d),
		.tanh_lo (tanh_lo),
		.tanh_d  (tanh_d)
	);

	assign use_tanh = (tag_s2.sel == FN_TANH) || (tag_s2.sel == FN_TANH_D);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			tag_s3 <= tag_s2;
			lo_s3  <= use_tanh ? tanh_lo : sig_lo;
			d_s3   <= use_tanh ? tanh_d : sig_d;
			r_s3   <= r_s2;
			lin_s3 <= lin_s2;
		end
	end

endmodule

// ----- design/nau_shape.sv -----
module nau_shape
	import nau_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                                                 clk,
	input  logic [2:0]                                           en,
	input  nau_tag_t                                             tag_s3,
	input  logic [FRAC_BITS:0]                                   lo_s3,
	input  logic [FRAC_BITS:0]                                   d_s3,
	input  logic [DATA_WIDTH-2:0]                                r_s3,
	input  logic signed [res_width(DATA_WIDTH, FRAC_BITS)-1:0] lin_s3,
	output logic signed [DATA_WIDTH-1:0]                         y_s6
);
	localparam int TW  = FRAC_BITS + 1;
	localparam int PRW = TW + DATA_WIDTH - 1;
	localparam int MW  = 2 * TW;
	localparam int RW  = res_width(DATA_WIDTH, FRAC_BITS);

	localparam logic [TW-1:0]        ONE   = TW'(longint'(1) << FRAC_BITS);
	localparam logic [MW-1:0]        HALF  = MW'(longint'(1) << (FRAC_BITS - 1));
	localparam logic signed [RW-1:0] ONE_R = RW'(longint'(1) << FRAC_BITS);
	localparam logic signed [RW-1:0] Y_MAX = RW'((longint'(1) << (DATA_WIDTH - 1)) - 1);
	localparam logic signed [RW-1:0] Y_MIN = RW'(-(longint'(1) << (DATA_WIDTH - 1)));

	nau_tag_t             tag_s4;
	nau_tag_t             tag_s5;
	logic [TW-1:0]        v_s4;
	logic signed [RW-1:0] lin_s4;
	logic signed [RW-1:0] res_s5;
	logic [TW-1:0]        ma_s5;
	logic [TW-1:0]        mb_s5;

	logic [PRW-1:0]       step;
	logic [TW-1:0]        s_val;
	logic signed [RW-1:0] res;
	logic [TW-1:0]        ma;
	logic [TW-1:0]        mb;
	logic [MW-1:0]        prod;
	logic [TW-1:0]        prod_q;
	logic signed [RW-1:0] full;
	logic signed [RW-1:0] sat;

	// Linear interpolation between two table points.
	assign step = PRW'(d_s3) * PRW'(r_s3);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			tag_s4 <= tag_s3;
			v_s4   <= lo_s3 + TW'(step >> (DATA_WIDTH - 1));
			lin_s4 <= lin_s3;
		end
	end

	// Sigmoid is mirrored around one half for negative inputs, tanh around zero.
	assign s_val = tag_s4.neg ? (ONE - v_s4) : v_s4;

	always_comb begin
		ma  = s_val;
		mb  = ONE - s_val;
		res = lin_s4;
		case (tag_s4.sel)
			FN_SIGMOID:   res = RW'(s_val);
			FN_SIGMOID_D: res = '0;
			FN_TANH:      res = tag_s4.neg ? (RW'(0) - RW'(v_s4)) : RW'(v_s4);
			FN_TANH_D: begin
				ma  = v_s4;
				mb  = v_s4;
				res = '0;
			end
			default:      res = lin_s4;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			tag_s5 <= tag_s4;
			res_s5 <= res;
			ma_s5  <= ma;
			mb_s5  <= mb;
		end
	end

	assign prod   = (MW'(ma_s5) * MW'(mb_s5) + HALF) >> FRAC_BITS;
	assign prod_q = prod[TW-1:0];

	always_comb begin
		case (tag_s5.sel)
			FN_SIGMOID_D: full = RW'(prod_q);
			FN_TANH_D:    full = ONE_R - RW'(prod_q);
			default:      full = res_s5;
		endcase
		if (full > Y_MAX) begin
			sat = Y_MAX;
		end else if (full < Y_MIN) begin
			sat = Y_MIN;
		end else begin
			sat = full;
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			y_s6 <= sat[DATA_WIDTH-1:0];
		end
	end

endmodule
